/* hw/rtl/psr_pkg.sv */
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the polyline step resampler.
// ----------------------------------------------------------------------------
package psr_pkg;

   localparam int unsigned COORD_W    = 36;  // signed Q27.8 coordinate
   localparam int unsigned DIFF_W     = 37;  // magnitude of a coordinate difference
   localparam int unsigned STEP_W     = 24;  // unsigned Q16.8 step
   localparam int unsigned MUL_W      = 30;  // operand width of the shared multiplier
   localparam int unsigned PROD_W     = 60;
   localparam int unsigned ACC_W      = 61;  // sum of two squares
   localparam int unsigned ROOT_W     = 62;
   localparam int unsigned QUOT_W     = 25;  // quotient bits of one offset
   localparam int unsigned DIVD_W     = 31;  // width of the square root result
   localparam int unsigned NUM_W      = 55;
   localparam int unsigned MAX_RUN_DEF = 64;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_STEP_DISTANCE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_FAR_X,
      ST_FAR_Y,
      ST_FAR_S,
      ST_FAR_CMP,
      ST_EMIT,
      ST_SHIFT,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_S,
      ST_SQRT,
      ST_NUM,
      ST_DLOAD,
      ST_DIV,
      ST_UPD
   } state_type;

endpackage

/* hw/rtl/psr_mul.sv */
// ----------------------------------------------------------------------------
// psr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module psr_mul (
   input  logic                          clock,
   input  logic [psr_pkg::MUL_W-1:0]     op_a,
   input  logic [psr_pkg::MUL_W-1:0]     op_b,
   output logic [psr_pkg::PROD_W-1:0]    prod
);

   logic [psr_pkg::PROD_W-1:0] prod_ff;
   logic [psr_pkg::PROD_W-1:0] prod_in;

   assign prod_in = {{(psr_pkg::PROD_W-psr_pkg::MUL_W){1'b0}}, op_a} *
                    {{(psr_pkg::PROD_W-psr_pkg::MUL_W){1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/polyline_step_resampler_unit.sv */
// ----------------------------------------------------------------------------
// polyline_step_resampler_unit
// Resamples a polyline at a fixed step, one vertex word at a time.
// ----------------------------------------------------------------------------
// A vertex word marked first_vertex, or any vertex while step_distance is zero,
// is sent back unchanged as one result word and becomes the anchor. Otherwise
// the unit works one vertex at a time and holds req_ready low until it is done.
// For each resampled point it forms the distance test (the difference, then
// squares of both axes and of the step on the shared multiplier), normalizes
// the difference by shifting, squares and sums, takes an integer square root
// one result bit a cycle and divides for each axis one quotient bit a cycle;
// the square root loop and the serial divider take most of the time of each
// emitted point. A vertex nearer than the step holds req_ready low through the
// difference and distance test states and gives no word.
// A run holds at most MAX_RUN points; the last word of a run carries run_last,
// and run_truncated when the cap cut the run short. Each result word waits in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module polyline_step_resampler_unit #(
   parameter int unsigned MAX_RUN = psr_pkg::MAX_RUN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input words
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [psr_pkg::COORD_W-1:0] req_vertex_x,
   input  logic signed [psr_pkg::COORD_W-1:0] req_vertex_y,
   input  logic                               req_first_vertex,
   // Result words
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [psr_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [psr_pkg::COORD_W-1:0] rsp_out_y,
   output logic                               rsp_run_last,
   output logic                               rsp_run_truncated,
   // Register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [psr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [psr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [psr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RUN);

   psr_pkg::state_type state_ff, state_in;

   // Control registers.
   logic [psr_pkg::STEP_W-1:0]         step_ff;
   logic [CNT_W-1:0]                   cnt_ff;
   logic                               have_pt_ff;
   logic signed [psr_pkg::COORD_W-1:0] anchor_x_ff;
   logic signed [psr_pkg::COORD_W-1:0] anchor_y_ff;

   // Payload registers.
   logic signed [psr_pkg::COORD_W-1:0] vx_ff, vy_ff;
   logic [psr_pkg::DIFF_W-1:0]         mag_x_ff, mag_y_ff;
   logic                               sgn_x_ff, sgn_y_ff;
   logic                               big_ff;
   logic [psr_pkg::ACC_W-1:0]          acc_ff;
   logic [psr_pkg::ROOT_W-1:0]         root_ff;
   logic [psr_pkg::ACC_W-1:0]          bit_ff;
   logic [psr_pkg::DIVD_W-1:0]         rem_ff;
   logic [psr_pkg::QUOT_W-1:0]         qsh_ff;
   logic [4:0]                         divcnt_ff;
   logic                               axis_ff;
   logic signed [psr_pkg::COORD_W-1:0] out_x_ff, out_y_ff;
   logic                               last_ff, trunc_ff;

   // Shared multiplier.
   logic [psr_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [psr_pkg::PROD_W-1:0] prod;

   psr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Register port: no wait states. A write lands at the access phase.
   logic csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & (paddr[2] == psr_pkg::REG_STEP_DISTANCE);

   always_comb begin
      if (paddr[2] == psr_pkg::REG_STEP_DISTANCE) begin
         prdata = {{(psr_pkg::CSR_DATA_W-psr_pkg::STEP_W){1'b0}}, step_ff};
      end else begin
         prdata = '0;
      end
   end

   logic accept_in;
   assign accept_in = req_valid & req_ready;

   logic pass_thru;
   assign pass_thru = req_first_vertex | (step_ff == '0);

   // Difference from the anchor, as sign and magnitude.
   logic signed [psr_pkg::DIFF_W-1:0] dx, dy;
   assign dx = {vx_ff[psr_pkg::COORD_W-1], vx_ff} - {anchor_x_ff[psr_pkg::COORD_W-1], anchor_x_ff};
   assign dy = {vy_ff[psr_pkg::COORD_W-1], vy_ff} - {anchor_y_ff[psr_pkg::COORD_W-1], anchor_y_ff};

   // The distance is at least the step when either axis is huge or the
   // squared distance reaches the squared step.
   logic far;
   assign far = big_ff | (acc_ff >= {1'b0, prod});

   logic at_cap;
   assign at_cap = (cnt_ff == CNT_MAX);

   logic over;
   assign over = (|mag_x_ff[psr_pkg::DIFF_W-1:psr_pkg::MUL_W]) |
                 (|mag_y_ff[psr_pkg::DIFF_W-1:psr_pkg::MUL_W]);

   // One step of the bitwise square root.
   logic [psr_pkg::ROOT_W:0] sq_trial;
   logic                     sq_ge;
   assign sq_trial = {1'b0, root_ff} + {2'b00, bit_ff};
   assign sq_ge    = {2'b00, acc_ff} >= sq_trial;

   // One step of the restoring divider. The root is the divisor.
   logic [psr_pkg::DIVD_W-1:0] divisor;
   logic [psr_pkg::DIVD_W:0]   rem2;
   logic                       div_ge;
   logic [psr_pkg::DIVD_W:0]   rem_sub;
   assign divisor = root_ff[psr_pkg::DIVD_W-1:0];
   assign rem2    = {rem_ff, qsh_ff[psr_pkg::QUOT_W-1]};
   assign div_ge  = rem2 >= {1'b0, divisor};
   assign rem_sub = rem2 - {1'b0, divisor};

   // Rounded numerator m * step + floor(D / 2).
   logic [psr_pkg::NUM_W:0] numer;
   assign numer = {1'b0, prod[psr_pkg::NUM_W-1:0]} +
                  {{(psr_pkg::NUM_W+1-psr_pkg::DIVD_W+1){1'b0}},
                   divisor[psr_pkg::DIVD_W-1:1]};

   // Signed offset for the axis being finished.
   logic [psr_pkg::COORD_W-1:0] offs;
   logic                        offs_neg;
   assign offs_neg = axis_ff ? sgn_y_ff : sgn_x_ff;
   assign offs = offs_neg ?
                 (~{{(psr_pkg::COORD_W-psr_pkg::QUOT_W){1'b0}}, qsh_ff} + 1'b1) :
                 {{(psr_pkg::COORD_W-psr_pkg::QUOT_W){1'b0}}, qsh_ff};

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         psr_pkg::ST_FAR_X: begin
            mul_a = {{(psr_pkg::MUL_W-24){1'b0}}, mag_x_ff[23:0]};
            mul_b = mul_a;
         end
         psr_pkg::ST_FAR_Y: begin
            mul_a = {{(psr_pkg::MUL_W-24){1'b0}}, mag_y_ff[23:0]};
            mul_b = mul_a;
         end
         psr_pkg::ST_FAR_S: begin
            mul_a = {{(psr_pkg::MUL_W-psr_pkg::STEP_W){1'b0}}, step_ff};
            mul_b = mul_a;
         end
         psr_pkg::ST_SQ_X: begin
            mul_a = mag_x_ff[psr_pkg::MUL_W-1:0];
            mul_b = mul_a;
         end
         psr_pkg::ST_SQ_Y: begin
            mul_a = mag_y_ff[psr_pkg::MUL_W-1:0];
            mul_b = mul_a;
         end
         psr_pkg::ST_NUM: begin
            mul_a = axis_ff ? mag_y_ff[psr_pkg::MUL_W-1:0] : mag_x_ff[psr_pkg::MUL_W-1:0];
            mul_b = {{(psr_pkg::MUL_W-psr_pkg::STEP_W){1'b0}}, step_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pass_thru ? psr_pkg::ST_EMIT : psr_pkg::ST_DIFF;
            end
         end
         psr_pkg::ST_DIFF:  state_in = psr_pkg::ST_FAR_X;
         psr_pkg::ST_FAR_X: state_in = psr_pkg::ST_FAR_Y;
         psr_pkg::ST_FAR_Y: state_in = psr_pkg::ST_FAR_S;
         psr_pkg::ST_FAR_S: state_in = psr_pkg::ST_FAR_CMP;
         psr_pkg::ST_FAR_CMP: begin
            if (have_pt_ff) begin
               state_in = psr_pkg::ST_EMIT;
            end else begin
               state_in = far ? psr_pkg::ST_SHIFT : psr_pkg::ST_IDLE;
            end
         end
         psr_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               state_in = last_ff ? psr_pkg::ST_IDLE : psr_pkg::ST_SHIFT;
            end
         end
         psr_pkg::ST_SHIFT: state_in = over ? psr_pkg::ST_SHIFT : psr_pkg::ST_SQ_X;
         psr_pkg::ST_SQ_X:  state_in = psr_pkg::ST_SQ_Y;
         psr_pkg::ST_SQ_Y:  state_in = psr_pkg::ST_SQ_S;
         psr_pkg::ST_SQ_S:  state_in = psr_pkg::ST_SQRT;
         psr_pkg::ST_SQRT:  state_in = bit_ff[0] ? psr_pkg::ST_NUM : psr_pkg::ST_SQRT;
         psr_pkg::ST_NUM:   state_in = psr_pkg::ST_DLOAD;
         psr_pkg::ST_DLOAD: state_in = psr_pkg::ST_DIV;
         psr_pkg::ST_DIV: begin
            if (divcnt_ff == 5'(psr_pkg::QUOT_W - 1)) begin
               state_in = psr_pkg::ST_UPD;
            end
         end
         psr_pkg::ST_UPD:   state_in = axis_ff ? psr_pkg::ST_DIFF : psr_pkg::ST_NUM;
         default:           state_in = psr_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready = (state_ff == psr_pkg::ST_IDLE);
      rsp_valid = (state_ff == psr_pkg::ST_EMIT);
   end

   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_run_last      = last_ff;
   assign rsp_run_truncated = trunc_ff;

   // Control state: sequencer, step register, run count, point and axis flags and anchor.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= psr_pkg::ST_IDLE;
         step_ff     <= '0;
         cnt_ff      <= '0;
         have_pt_ff  <= 1'b0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         axis_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            step_ff <= pwdata[psr_pkg::STEP_W-1:0];
         end
         if (accept_in) begin
            cnt_ff     <= '0;
            have_pt_ff <= 1'b0;
            axis_ff    <= 1'b0;
            if (pass_thru) begin
               anchor_x_ff <= req_vertex_x;
               anchor_y_ff <= req_vertex_y;
            end
         end
         if (state_ff == psr_pkg::ST_UPD) begin
            axis_ff <= ~axis_ff;
            if (axis_ff) begin
               anchor_y_ff <= anchor_y_ff + offs;
               cnt_ff      <= cnt_ff + 1'b1;
               have_pt_ff  <= 1'b1;
            end else begin
               anchor_x_ff <= anchor_x_ff + offs;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         psr_pkg::ST_IDLE: begin
            vx_ff    <= req_vertex_x;
            vy_ff    <= req_vertex_y;
            out_x_ff <= req_vertex_x;
            out_y_ff <= req_vertex_y;
            last_ff  <= 1'b1;
            trunc_ff <= 1'b0;
         end
         psr_pkg::ST_DIFF: begin
            sgn_x_ff <= dx[psr_pkg::DIFF_W-1];
            sgn_y_ff <= dy[psr_pkg::DIFF_W-1];
            mag_x_ff <= dx[psr_pkg::DIFF_W-1] ? -dx : dx;
            mag_y_ff <= dy[psr_pkg::DIFF_W-1] ? -dy : dy;
         end
         psr_pkg::ST_FAR_X: begin
            big_ff <= (|mag_x_ff[psr_pkg::DIFF_W-1:24]) | (|mag_y_ff[psr_pkg::DIFF_W-1:24]);
         end
         psr_pkg::ST_FAR_Y: begin
            acc_ff <= {1'b0, prod};
         end
         psr_pkg::ST_FAR_S: begin
            acc_ff <= acc_ff + {1'b0, prod};
         end
         psr_pkg::ST_FAR_CMP: begin
            out_x_ff <= anchor_x_ff;
            out_y_ff <= anchor_y_ff;
            last_ff  <= ~far | at_cap;
            trunc_ff <= far & at_cap;
         end
         psr_pkg::ST_SHIFT: begin
            if (over) begin
               mag_x_ff <= mag_x_ff >> 1;
               mag_y_ff <= mag_y_ff >> 1;
            end
         end
         psr_pkg::ST_SQ_Y: begin
            acc_ff <= {1'b0, prod};
         end
         psr_pkg::ST_SQ_S: begin
            acc_ff  <= acc_ff + {1'b0, prod};
            root_ff <= '0;
            bit_ff  <= {1'b1, {(psr_pkg::ACC_W-1){1'b0}}};
         end
         psr_pkg::ST_SQRT: begin
            if (sq_ge) begin
               acc_ff  <= acc_ff - sq_trial[psr_pkg::ACC_W-1:0];
               root_ff <= (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         psr_pkg::ST_DLOAD: begin
            rem_ff    <= {1'b0, numer[psr_pkg::NUM_W-1:psr_pkg::QUOT_W]};
            qsh_ff    <= numer[psr_pkg::QUOT_W-1:0];
            divcnt_ff <= '0;
         end
         psr_pkg::ST_DIV: begin
            rem_ff    <= div_ge ? rem_sub[psr_pkg::DIVD_W-1:0] : rem2[psr_pkg::DIVD_W-1:0];
            qsh_ff    <= {qsh_ff[psr_pkg::QUOT_W-2:0], div_ge};
            divcnt_ff <= divcnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* hw/rtl/psr_checker.sv */
// ----------------------------------------------------------------------------
// psr_checker
// Port-level checks of the polyline step resampler, bound to the top level.
// ----------------------------------------------------------------------------
module psr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [psr_pkg::COORD_W-1:0] req_vertex_x,
   input logic signed [psr_pkg::COORD_W-1:0] req_vertex_y,
   input logic                               req_first_vertex,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [psr_pkg::COORD_W-1:0] rsp_out_x,
   input logic signed [psr_pkg::COORD_W-1:0] rsp_out_y,
   input logic                               rsp_run_last,
   input logic                               rsp_run_truncated
);

   // A waiting result word keeps its coordinates and run_last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                  && $stable(rsp_run_last))
      else $error("result word changed while stalled");

   // The unit takes no new vertex while a result word is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a result is pending");

   // Truncation is only flagged on the final word of a run.
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_truncated |-> rsp_run_last)
      else $error("truncated flag without run_last");

   // A first vertex comes straight back as a single word.
   a_first_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_first_vertex |=>
         rsp_valid && rsp_run_last && !rsp_run_truncated
         && rsp_out_x == $past(req_vertex_x) && rsp_out_y == $past(req_vertex_y))
      else $error("first vertex not echoed");

endmodule

bind polyline_step_resampler_unit psr_checker u_psr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_vertex_x      (req_vertex_x),
   .req_vertex_y      (req_vertex_y),
   .req_first_vertex  (req_first_vertex),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_x         (rsp_out_x),
   .rsp_out_y         (rsp_out_y),
   .rsp_run_last      (rsp_run_last),
   .rsp_run_truncated (rsp_run_truncated)
);

/* verif/tb_polyline_step_resampler_unit.sv */
// ----------------------------------------------------------------------------
// tb_polyline_step_resampler_unit
// Self-checking testbench of the polyline step resampler.
// ----------------------------------------------------------------------------
// Vertex words go in through the request channel and resampled point words
// come back through the response channel. A scoreboard class predicts every
// point word from its own copy of the anchor and the step. Each accepted
// response is compared with the oldest predicted word. The step register is
// rewritten between phases, and only while the unit is idle. Both channels
// pause at random.
// ----------------------------------------------------------------------------
module tb_polyline_step_resampler_unit;

   localparam int unsigned COORD_W     = psr_pkg::COORD_W;
   localparam int unsigned STEP_W      = psr_pkg::STEP_W;
   localparam int unsigned CSR_ADDR_W  = psr_pkg::CSR_ADDR_W;
   localparam int unsigned CSR_DATA_W  = psr_pkg::CSR_DATA_W;
   localparam int unsigned RUN_CAP     = 64;
   localparam longint      CYCLE_LIMIT = 40000000;
   localparam int unsigned SETTLE      = 400;   // cycles for a near vertex to finish
   localparam logic [CSR_ADDR_W-1:0] STEP_ADDR =
      CSR_ADDR_W'(4 * psr_pkg::REG_STEP_DISTANCE);

   typedef bit [63:0] u64_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
      logic               trunc;
   } point_word_type;

   // Predicts the resampled points and holds the words not yet returned.
   class resample_scoreboard;
      longint         anchor_x, anchor_y;
      bit [63:0]      step;
      point_word_type pending_points[$];
      int             errors;
      int             words_seen;
      int             truncated_runs;

      function new();
         anchor_x = 0; anchor_y = 0; step = 0; errors = 0;
         words_seen = 0; truncated_runs = 0;
      endfunction

      function longint wrap36(bit [63:0] v);
         return longint'({{28{v[35]}}, v[35:0]});
      endfunction

      function bit [63:0] magnitude(longint v);
         return v < 0 ? u64_type'(0) - u64_type'(v) : u64_type'(v);
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] n);
         bit [63:0] root, b;
         root = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= root + b) begin
               n = n - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      function bit reaches_step(longint dx, longint dy);
         bit [63:0] ax, ay;
         ax = magnitude(dx);
         ay = magnitude(dy);
         if (ax >= (64'd1 << 24) || ay >= (64'd1 << 24)) return 1;
         return ax * ax + ay * ay >= step * step;
      endfunction

      function longint axis_offset(longint d, bit [63:0] m, bit [63:0] root_len);
         bit [63:0] q;
         q = (m * step + (root_len >> 1)) / root_len;
         return d < 0 ? -longint'(q) : longint'(q);
      endfunction

      function void push(longint x, longint y, bit last, bit trunc);
         point_word_type w;
         w.x = x[COORD_W-1:0];
         w.y = y[COORD_W-1:0];
         w.last = last;
         w.trunc = trunc;
         pending_points.push_back(w);
      endfunction

      // Called for every vertex word the unit accepts.
      function void note_vertex(logic [COORD_W-1:0] vx_in, logic [COORD_W-1:0] vy_in,
                                logic first);
         longint    vx, vy, dx, dy;
         bit [63:0] mx, my, root_len;
         int        n;
         bit        trunc;
         vx = wrap36(64'(vx_in));
         vy = wrap36(64'(vy_in));
         n = 0;
         if (first || step == 0) begin
            anchor_x = vx;
            anchor_y = vy;
            push(vx, vy, 1'b1, 1'b0);
            return;
         end
         while (n < RUN_CAP) begin
            dx = vx - anchor_x;
            dy = vy - anchor_y;
            if (!reaches_step(dx, dy)) break;
            mx = magnitude(dx);
            my = magnitude(dy);
            while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
               mx = mx >> 1;
               my = my >> 1;
            end
            root_len = int_sqrt(mx * mx + my * my);
            if (root_len == 0) break;
            anchor_x = wrap36(u64_type'(anchor_x + axis_offset(dx, mx, root_len)));
            anchor_y = wrap36(u64_type'(anchor_y + axis_offset(dy, my, root_len)));
            push(anchor_x, anchor_y, 1'b0, 1'b0);
            n++;
         end
         if (n > 0) begin
            trunc = (n >= RUN_CAP) && reaches_step(vx - anchor_x, vy - anchor_y);
            pending_points[$].last = 1'b1;
            pending_points[$].trunc = trunc;
            if (trunc) truncated_runs++;
         end
      endfunction

      // Called for every point word the unit hands over.
      function void check_point(point_word_type got);
         point_word_type want;
         words_seen++;
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point word x=%h y=%h", $time, got.x, got.y);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         if (want.x !== got.x) begin
            $display("%0t: out_x expected %h got %h", $time, want.x, got.x);
            errors++;
         end
         if (want.y !== got.y) begin
            $display("%0t: out_y expected %h got %h", $time, want.y, got.y);
            errors++;
         end
         if (want.last !== got.last) begin
            $display("%0t: run_last expected %b got %b", $time, want.last, got.last);
            errors++;
         end
         if (want.trunc !== got.trunc) begin
            $display("%0t: run_truncated expected %b got %b", $time, want.trunc, got.trunc);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_vertex_x = '0;
   logic signed [COORD_W-1:0] req_vertex_y = '0;
   logic                      req_first_vertex = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic                      rsp_run_last;
   logic                      rsp_run_truncated;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   resample_scoreboard sb = new();
   longint  cycle_count = 0;
   int      vertices_sent = 0;
   int      step_settings = 0;
   longint  last_x = 0, last_y = 0;

   polyline_step_resampler_unit dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_vertex_x, .req_vertex_y, .req_first_vertex,
      .rsp_valid, .rsp_ready, .rsp_out_x, .rsp_out_y, .rsp_run_last, .rsp_run_truncated,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The cycle counter doubles as the watchdog of the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: checks a word when the handshake completes and picks the
   // ready level for the next cycle. Stalls are mostly short, sometimes long,
   // and there are stretches where the consumer never stalls at all.
   int stall_left = 0;
   int calm_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_point('{rsp_out_x, rsp_out_y, rsp_run_last, rsp_run_truncated});
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else begin
         case ($urandom_range(9))
            0:       stall_left = $urandom_range(40, 150);
            1, 2, 3: stall_left = $urandom_range(1, 4);
            4:       calm_left = $urandom_range(50, 400);
            default: calm_left = 0;
         endcase
         rsp_ready <= (stall_left == 0);
      end
   end

   // Sends one vertex word, sometimes after an idle gap, and waits for the unit to take it.
   // The valid line is only dropped when there is a real gap, so it never gets
   // two assignments in one time step.
   task automatic send_vertex(logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy, logic first);
      int gap;
      case ($urandom_range(9))
         0:       gap = $urandom_range(20, 120);
         1, 2:    gap = $urandom_range(1, 3);
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_first_vertex <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_vertex(vx, vy, first);
      vertices_sent++;
      last_x = sb.wrap36(64'(vx));
      last_y = sb.wrap36(64'(vy));
   endtask

   // Lets every predicted word come back, then waits out a vertex that is
   // still being worked on without producing a word.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_points.size() != 0 || !req_ready) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write: setup cycle, then the access cycle.
   task automatic set_step(logic [STEP_W-1:0] value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= STEP_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.step = 64'(value);
      step_settings++;
      @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] any_coord();
      return COORD_W'({$urandom, $urandom});
   endfunction

   // A coordinate within span of the given one, wrapped to the field width.
   function automatic logic [COORD_W-1:0] near_coord(longint base, longint span);
      bit [63:0] r;
      r = {$urandom, $urandom};
      return COORD_W'(base + longint'(r % u64_type'(2 * span + 1)) - span);
   endfunction

   // Random stimulus under the current step: mostly polylines that wander by
   // a few steps per vertex, a few far jumps that can hit the run cap, some fresh
   // polylines and some noise anywhere in the coordinate range.
   task automatic random_phase(int count);
      longint span, unit_len;
      int     r;
      unit_len = (sb.step == 0) ? 1000 : longint'(sb.step);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (i == count / 2) drain();   // sender holds off until all words are back
         if (r < 8) begin
            send_vertex(any_coord(), any_coord(), 1'b1);
         end else if (r < 14) begin
            send_vertex(any_coord(), any_coord(), 1'b0);
         end else begin
            if (r < 16)      span = unit_len * $urandom_range(70, 100);
            else if (r < 30) span = unit_len / 2 + 1;
            else             span = unit_len * $urandom_range(1, 6);
            send_vertex(near_coord(last_x, span), near_coord(last_y, span), 1'b0);
         end
      end
   endtask

   localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [COORD_W-1:0] C_ZERO = '0;
   localparam logic [COORD_W-1:0] C_NEG1 = '1;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Before any first vertex the anchor is the reset origin,
      // so a vertex 3 m east and 4 m north gives a run of four points about 1 m apart.
      set_step(STEP_W'(256));
      send_vertex(COORD_W'(3 * 256), COORD_W'(4 * 256), 1'b0);
      // A vertex nearer than the step yields nothing and keeps the anchor.
      send_vertex(COORD_W'(3 * 256 + 10), COORD_W'(4 * 256 - 7), 1'b0);
      // First vertex at the top corner, then a jump across the whole range:
      // the run stops at the cap and carries the truncation flag.
      send_vertex(C_MAX, C_MAX, 1'b1);
      send_vertex(C_MIN, C_MIN, 1'b0);
      send_vertex(C_MIN, C_MAX, 1'b1);
      send_vertex(C_MAX, C_MIN, 1'b0);
      // Exactly one step away along an axis, then just over the step on a
      // diagonal close to a 3-4-5 triangle.
      send_vertex(C_ZERO, C_ZERO, 1'b1);
      send_vertex(COORD_W'(256), C_ZERO, 1'b0);
      send_vertex(COORD_W'(256 + 154), COORD_W'(205), 1'b0);

      // Pass-through: a zero step sends every vertex back unchanged.
      set_step(STEP_W'(0));
      send_vertex(C_MAX, C_MIN, 1'b0);
      send_vertex(C_MIN, C_MAX, 1'b0);
      send_vertex(C_NEG1, C_ZERO, 1'b0);
      send_vertex(C_ZERO, C_NEG1, 1'b1);

      // Largest step: the distance test goes by the coarse 2^24 bound.
      set_step('1);
      send_vertex(C_ZERO, C_ZERO, 1'b1);
      send_vertex(COORD_W'(64'd1 << 26), C_ZERO, 1'b0);
      send_vertex(C_NEG1, COORD_W'(-(64'd1 << 25)), 1'b0);
      send_vertex(C_MIN, C_MIN, 1'b0);

      // Smallest step: points about one unit apart, near the top of the range.
      set_step(STEP_W'(1));
      send_vertex(C_MAX - 5, C_MAX - 5, 1'b1);
      send_vertex(C_MAX, C_MAX - 2, 1'b0);
      send_vertex(C_NEG1, C_NEG1, 1'b0);

      // Random part over several step settings, the extremes among them.
      set_step(STEP_W'(256));      random_phase(80);
      set_step(STEP_W'(1));        random_phase(80);
      set_step('1);                random_phase(70);
      set_step(STEP_W'(0));        random_phase(60);
      set_step(STEP_W'($urandom)); random_phase(80);
      set_step(STEP_W'($urandom_range(2, 300))); random_phase(80);

      drain();
      $display("Covered %0d vertex words and %0d point words under %0d step settings,",
               vertices_sent, sb.words_seen, step_settings);
      $display("with %0d runs cut at the cap and random stalls on both channels.",
               sb.truncated_runs);
      if (sb.errors == 0 && sb.pending_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/psr_pkg.sv
hw/rtl/psr_mul.sv
hw/rtl/polyline_step_resampler_unit.sv
hw/rtl/psr_checker.sv
verif/tb_polyline_step_resampler_unit.sv
